// ===== hdl/mli_pkg.sv =====
// Package with the widths, request codes and constants of the memo line index unit.
`timescale 1ns / 1ps

package mli_pkg;

	localparam int POS_W         = 13;
	localparam int REQ_W         = 2;
	localparam int BYTE_W        = 8;
	localparam int BUF_DEPTH_DEF = 4096;
	localparam int S_TDATA_W     = 48;
	localparam int M_TDATA_W     = 32;

	localparam logic [BYTE_W-1:0] NL_CHAR = 8'h0A;

	localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_NOTIFY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LSTART = 2'd2;
	localparam logic [REQ_W-1:0] REQ_LATPOS = 2'd3;

	typedef logic [POS_W-1:0] pos_t;

endpackage

// ===== hdl/memo_line_index_unit.sv =====
// Memo line index unit: text store with a line memo that answers line start and line lookups.
`timescale 1ns / 1ps

// A write or a notify transaction is taken while idle and gives no result; the text store
// is a single synchronous memory whose contents are undefined until written. A query walks
// the text from the memo one byte per cycle through the single read port of that memory.
// A query passes through a prepare state, a backward walk where the memo lies past its
// target, a decide state, a forward walk where needed and a done state. A line start query
// for line 0 goes from the prepare state straight to the done state. A result that meets a
// full output register holds the query in its last state until the register frees. A new
// transaction is taken while the previous result still waits on the output register. No
// clearing pass follows reset.
module memo_line_index_unit #(
	parameter int BUF_DEPTH = mli_pkg::BUF_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// position[12:0], data_byte[20:13], line_number[33:21], buffer_length[46:34]
	input  logic [mli_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [mli_pkg::REQ_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_position[12:0], result_line[25:13]
	output logic [mli_pkg::M_TDATA_W-1:0]  m_tdata,
	// line_found[0]
	output logic                           m_tuser
);
	import mli_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_BACK   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FWD    = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [BYTE_W-1:0] text_mem [BUF_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [2:0]       state_q;
	logic [REQ_W-1:0] req_q;
	pos_t             pos_q, line_q, len_q;
	pos_t             memo_line_q, memo_start_q;
	pos_t             scan_q;
	logic             pend_s1;
	pos_t             addr_s1;
	pos_t             res_pos_q, res_line_q;
	logic             res_found_q;
	logic             m_valid_q;
	pos_t             m_pos_q, m_line_q;
	logic             m_found_q;

	pos_t             in_pos, in_line, in_len, len_sat, pos_clamp;
	logic [BYTE_W-1:0] in_byte;
	logic             in_acc, out_free;
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	pos_t             fwd_limit, prep_ms, prep_ml;
	logic             is_lstart, nl_hit;

	function automatic pos_t rd_addr_pos(input logic [2:0] st, input pos_t sc);
		pos_t a;
		a = (st == S_BACK) ? (sc - 1'b1) : sc;
		return a;
	endfunction

	assign in_pos  = s_tdata[12:0];
	assign in_byte = s_tdata[20:13];
	assign in_line = s_tdata[33:21];
	assign in_len  = s_tdata[46:34];

	assign len_sat   = (32'(in_len) > 32'(BUF_DEPTH)) ? POS_W'(BUF_DEPTH) : in_len;
	assign pos_clamp = (in_pos > len_sat) ? len_sat : in_pos;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign is_lstart = (req_q == REQ_LSTART);
	assign fwd_limit = is_lstart ? len_q : pos_q;
	assign prep_ms   = (memo_start_q > len_q) ? '0 : memo_start_q;
	assign prep_ml   = (memo_start_q > len_q) ? '0 : memo_line_q;
	assign nl_hit    = pend_s1 && (rd_data_q == NL_CHAR);

	assign wr_en   = in_acc && (s_tuser == REQ_WRITE) && (32'(in_pos) < 32'(BUF_DEPTH));
	assign wr_addr = AW'(in_pos);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(scan_q);
		if (state_q == S_BACK) begin
			rd_en   = (scan_q != '0);
			rd_addr = AW'(scan_q - 1'b1);
		end else if (state_q == S_FWD) begin
			rd_en   = (scan_q < fwd_limit);
			rd_addr = AW'(scan_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[wr_addr] <= in_byte;
		end
		if (rd_en) begin
			rd_data_q <= text_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			memo_line_q  <= '0;
			memo_start_q <= '0;
			pend_s1      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser == REQ_WRITE || s_tuser == REQ_NOTIFY) begin
							if (memo_start_q > in_pos) begin
								memo_line_q  <= '0;
								memo_start_q <= '0;
							end
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					pend_s1 <= 1'b0;
					if (is_lstart && line_q == '0) begin
						state_q <= S_DONE;
					end else if (is_lstart ? (prep_ml > line_q) : (prep_ms > pos_q)) begin
						if (prep_ms == '0 || prep_ml == '0) begin
							memo_start_q <= '0;
							memo_line_q  <= '0;
							state_q      <= S_DECIDE;
						end else begin
							memo_start_q <= prep_ms;
							memo_line_q  <= prep_ml;
							state_q      <= S_BACK;
						end
					end else begin
						memo_start_q <= prep_ms;
						memo_line_q  <= prep_ml;
						state_q      <= S_DECIDE;
					end
				end
				S_BACK: begin
					if (nl_hit) begin
						if (is_lstart ? ((memo_line_q - 1'b1) > line_q)
						              : ((addr_s1 + 1'b1) > pos_q)) begin
							if (memo_line_q == POS_W'(1)) begin
								memo_start_q <= '0;
								memo_line_q  <= '0;
								pend_s1      <= 1'b0;
								state_q      <= S_DECIDE;
							end else begin
								memo_start_q <= addr_s1 + 1'b1;
								memo_line_q  <= memo_line_q - 1'b1;
								pend_s1      <= rd_en;
							end
						end else begin
							memo_start_q <= addr_s1 + 1'b1;
							memo_line_q  <= memo_line_q - 1'b1;
							pend_s1      <= 1'b0;
							state_q      <= S_DECIDE;
						end
					end else if (!pend_s1 && scan_q == '0) begin
						pend_s1      <= rd_en;
						memo_start_q <= '0;
						if (is_lstart && (memo_line_q - 1'b1) > line_q) begin
							memo_line_q <= '0;
						end else begin
							memo_line_q <= memo_line_q - 1'b1;
						end
						state_q <= S_DECIDE;
					end else begin
						pend_s1 <= rd_en;
					end
				end
				S_DECIDE: begin
					pend_s1 <= 1'b0;
					if (is_lstart && memo_line_q == line_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FWD;
					end
				end
				S_FWD: begin
					if (nl_hit) begin
						memo_start_q <= addr_s1 + 1'b1;
						memo_line_q  <= memo_line_q + 1'b1;
						if (is_lstart && (memo_line_q + 1'b1) == line_q) begin
							pend_s1 <= 1'b0;
							state_q <= S_DONE;
						end else begin
							pend_s1 <= rd_en;
						end
					end else begin
						pend_s1 <= rd_en;
						if (!pend_s1 && scan_q >= fwd_limit) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= s_tuser;
			pos_q  <= pos_clamp;
			line_q <= in_line;
			len_q  <= len_sat;
		end
		if (rd_en) begin
			addr_s1 <= rd_addr_pos(state_q, scan_q);
		end
		unique case (state_q)
			S_PREP:   scan_q <= prep_ms - 1'b1;
			S_BACK:   if (rd_en) scan_q <= scan_q - 1'b1;
			S_DECIDE: scan_q <= memo_start_q;
			S_FWD:    if (rd_en) scan_q <= scan_q + 1'b1;
			default:  scan_q <= scan_q;
		endcase
		if (state_q == S_PREP) begin
			res_pos_q   <= '0;
			res_line_q  <= '0;
			res_found_q <= 1'b1;
		end else if (state_q == S_DECIDE) begin
			res_pos_q   <= memo_start_q;
			res_line_q  <= memo_line_q;
			res_found_q <= 1'b1;
		end else if (state_q == S_FWD) begin
			if (nl_hit) begin
				res_pos_q   <= addr_s1 + 1'b1;
				res_line_q  <= memo_line_q + 1'b1;
				res_found_q <= 1'b1;
			end else if (!pend_s1 && scan_q >= fwd_limit) begin
				res_pos_q   <= is_lstart ? len_q : memo_start_q;
				res_line_q  <= memo_line_q;
				res_found_q <= !is_lstart;
			end
		end
		if (state_q == S_DONE && out_free) begin
			m_pos_q   <= res_pos_q;
			m_line_q  <= res_line_q;
			m_found_q <= res_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W - 2*POS_W){1'b0}}, m_line_q, m_pos_q};
	assign m_tuser  = m_found_q;

	a_query_enters_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == REQ_LSTART || s_tuser == REQ_LATPOS) |=> state_q == S_PREP)
		else $error("query transaction did not start a walk");

	a_notify_clears_memo: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == REQ_WRITE || s_tuser == REQ_NOTIFY) && in_pos < memo_start_q
		|=> memo_start_q == '0 && memo_line_q == '0)
		else $error("memo not cleared by a transaction before its start");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && m_valid_q && !m_tready |=> state_q == S_DONE && $stable(m_tdata))
		else $error("result overwrote an untaken output");

	a_fwd_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FWD && pend_s1 |-> addr_s1 < fwd_limit)
		else $error("forward walk read beyond its limit");

endmodule

// ===== dv/tb_memo_line_index_unit.sv =====
// Self-checking testbench for the memo line index unit, with a line walking predictor.
`timescale 1ns / 1ps

module tb_memo_line_index_unit;

	import mli_pkg::*;

	localparam int DEPTH        = BUF_DEPTH_DEF;
	localparam int QUIET_LIMIT  = 40000;
	localparam int RANDOM_ITEMS = 300;
	localparam int LOAD_BYTES   = 1024;

	typedef struct {
		logic [REQ_W-1:0]  req;
		pos_t              pos;
		logic [BYTE_W-1:0] dat;
		pos_t              line;
		pos_t              len;
		int                phase;
		bit                hold;
	} stim_item_t;

	typedef struct packed {
		pos_t rpos;
		pos_t rline;
		logic found;
	} line_answer_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;

	stim_item_t   item_q[$];
	line_answer_t answer_q[$];
	int           answers_left = 0;
	int           phase_now = 1;
	int           quiet_cycles = 0;
	int           n_errors = 0;
	int           n_writes = 0;
	int           n_notifies = 0;
	int           n_queries = 0;
	int           n_absent = 0;
	int           n_checked = 0;

	logic [BYTE_W-1:0] shadow_text [DEPTH];
	int unsigned       cached_line = 0;
	int unsigned       cached_start = 0;

	memo_line_index_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [BYTE_W-1:0] text_at(int unsigned p);
		return (p < DEPTH) ? shadow_text[p] : '0;
	endfunction

	function automatic void memo_reset();
		cached_line = 0;
		cached_start = 0;
	endfunction

	function automatic void memo_step_back();
		int unsigned p;
		if (cached_start == 0 || cached_line == 0) begin
			memo_reset();
			return;
		end
		p = cached_start - 1;
		while (p > 0 && text_at(p - 1) != NL_CHAR)
			p--;
		cached_start = p;
		cached_line--;
	endfunction

	function automatic int unsigned next_newline(int unsigned p, int unsigned lim);
		while (p < lim && text_at(p) != NL_CHAR)
			p++;
		return p;
	endfunction

	// Applies one transaction to the shadow state; returns 1 when an answer is due.
	function automatic bit predict_answer(input logic [REQ_W-1:0] req, input pos_t pos_in,
			input logic [BYTE_W-1:0] dat, input pos_t line_in, input pos_t len_in,
			output line_answer_t ans);
		int unsigned pos;
		int unsigned line;
		int unsigned len;
		int unsigned p;
		bit          found;
		pos = 32'(pos_in);
		line = 32'(line_in);
		len = 32'(len_in);
		found = 1'b1;
		ans = '0;
		if (len > DEPTH)
			len = DEPTH;
		case (req)
			REQ_WRITE: begin
				if (pos < DEPTH)
					shadow_text[pos] = dat;
				if (cached_start > pos)
					memo_reset();
				return 1'b0;
			end
			REQ_NOTIFY: begin
				if (cached_start > pos)
					memo_reset();
				return 1'b0;
			end
			REQ_LSTART: begin
				if (line != 0) begin
					if (cached_start > len)
						memo_reset();
					while (cached_line > line)
						memo_step_back();
					while (cached_line < line) begin
						p = next_newline(cached_start, len);
						if (p >= len) begin
							found = 1'b0;
							break;
						end
						cached_start = p + 1;
						cached_line++;
					end
					ans.rpos = pos_t'(found ? cached_start : len);
					ans.rline = pos_t'(cached_line);
				end
			end
			default: begin
				if (pos > len)
					pos = len;
				if (cached_start > len)
					memo_reset();
				while (cached_start > pos)
					memo_step_back();
				while (cached_start < pos) begin
					p = next_newline(cached_start, len);
					if (p >= pos || p >= len)
						break;
					cached_start = p + 1;
					cached_line++;
				end
				ans.rpos = pos_t'(cached_start);
				ans.rline = pos_t'(cached_line);
			end
		endcase
		ans.found = found;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic push_item(logic [REQ_W-1:0] req, int pos, int dat, int line, int len,
			int phase, bit hold);
		stim_item_t it;
		it.req = req;
		it.pos = pos_t'(pos);
		it.dat = BYTE_W'(dat);
		it.line = pos_t'(line);
		it.len = pos_t'(len);
		it.phase = phase;
		it.hold = hold;
		item_q.push_back(it);
	endtask

	// Mostly short lengths near the start of the text so that walks stay short.
	task automatic add_random_item(int phase, bit hold);
		int pick;
		int pos;
		int dat;
		int line;
		int len;
		pick = $urandom_range(99);
		dat = ($urandom_range(4) == 0) ? NL_CHAR : $urandom_range(255);
		line = $urandom_range(8191);
		len = $urandom_range(8191);
		if (pick < 35) begin
			pick = $urandom_range(99);
			pos = (pick < 70) ? $urandom_range(400) :
				(pick < 85) ? $urandom_range(DEPTH - 1) : $urandom_range(8191, DEPTH);
			push_item(REQ_WRITE, pos, dat, line, len, phase, hold);
		end else if (pick < 45) begin
			pos = ($urandom_range(1) == 0) ? $urandom_range(400) : $urandom_range(8191);
			push_item(REQ_NOTIFY, pos, dat, line, len, phase, hold);
		end else begin
			pick = $urandom_range(99);
			len = (pick < 90) ? $urandom_range(320) : $urandom_range(LOAD_BYTES);
			pick = $urandom_range(99);
			if (pick < 50) begin
				pick = $urandom_range(99);
				line = (pick < 70) ? $urandom_range(40) :
					(pick < 85) ? $urandom_range(400) :
					(pick < 95) ? $urandom_range(8191) : 0;
				push_item(REQ_LSTART, $urandom_range(8191), dat, line, len, phase, hold);
			end else begin
				pick = $urandom_range(99);
				pos = (pick < 70) ? $urandom_range(340) :
					(pick < 90) ? $urandom_range(8191) : len;
				push_item(REQ_LATPOS, pos, dat, line, len, phase, hold);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		stim_item_t nxt;
		bit         took;
		bit         ok;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			took = s_tvalid && s_tready;
			if (!s_tvalid || took) begin
				ok = item_q.size() != 0;
				if (ok)
					ok = $urandom_range(99) >=
						(item_q[0].phase == 1 ? 7 : item_q[0].phase == 2 ? 74 : 0);
				// A held transaction waits until every answer so far has come back.
				if (ok && item_q[0].hold && (took || answers_left != 0))
					ok = 1'b0;
				if (ok) begin
					nxt = item_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, nxt.len, nxt.line, nxt.dat, nxt.pos};
					s_tuser <= nxt.req;
					phase_now <= nxt.phase;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_proc
		line_answer_t want;
		line_answer_t due;
		if (!arst_n) begin
			m_tready <= 1'b0;
			answers_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("answer with no query waiting", m_tdata[12:0], 0);
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[12:0] != want.rpos)
						report_mismatch("result_position", m_tdata[12:0], want.rpos);
					if (m_tdata[25:13] != want.rline)
						report_mismatch("result_line", m_tdata[25:13], want.rline);
					if (m_tuser != want.found)
						report_mismatch("line_found", m_tuser, want.found);
					n_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					REQ_WRITE: n_writes++;
					REQ_NOTIFY: n_notifies++;
					default: n_queries++;
				endcase
				if (predict_answer(s_tuser, s_tdata[12:0], s_tdata[20:13], s_tdata[33:21],
						s_tdata[46:34], due)) begin
					answer_q.push_back(due);
					if (!due.found)
						n_absent++;
				end
			end
			answers_left <= answer_q.size();
			m_tready <= $urandom_range(99) >= (phase_now == 1 ? 74 : phase_now == 2 ? 7 : 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAIL memo_line_index_unit");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// Empty text first, then a short text with bytes at both extremes.
		push_item(REQ_LSTART, 0, 0, 0, 0, 1, 0);
		push_item(REQ_LATPOS, 0, 0, 0, 0, 1, 0);
		push_item(REQ_LSTART, 0, 0, 1, 0, 1, 0);
		push_item(REQ_WRITE, 0, 8'hFF, 8191, 8191, 1, 0);
		push_item(REQ_WRITE, 1, NL_CHAR, 0, 0, 1, 0);
		push_item(REQ_WRITE, 2, NL_CHAR, 8191, 0, 1, 0);
		push_item(REQ_WRITE, 3, 8'h00, 0, 8191, 1, 0);
		push_item(REQ_WRITE, 4, 8'h63, 0, 0, 1, 0);
		push_item(REQ_WRITE, 5, NL_CHAR, 0, 0, 1, 0);
		push_item(REQ_WRITE, 8191, 8'hFF, 0, 0, 1, 0);
		push_item(REQ_LSTART, 0, 0, 3, 6, 1, 0);
		push_item(REQ_LSTART, 0, 0, 4, 6, 1, 0);
		push_item(REQ_LSTART, 0, 0, 1, 6, 1, 0);
		push_item(REQ_LATPOS, 4, 0, 0, 6, 1, 0);
		push_item(REQ_LATPOS, 8191, 0, 0, 5, 1, 0);
		push_item(REQ_NOTIFY, 8191, 0, 0, 0, 1, 0);
		push_item(REQ_LSTART, 0, 0, 2, 6, 1, 0);
		push_item(REQ_WRITE, 1, 8'h78, 0, 0, 1, 0);
		push_item(REQ_LATPOS, 5, 0, 0, 6, 1, 0);
		push_item(REQ_NOTIFY, 0, 0, 0, 0, 1, 0);
		push_item(REQ_LATPOS, 6, 0, 0, 6, 1, 0);
		push_item(REQ_LATPOS, 1, 0, 0, 2, 1, 0);
		// Load the first part of the store; most later queries keep their lengths within it.
		for (int i = 0; i < LOAD_BYTES; i++)
			push_item(REQ_WRITE, i, ($urandom_range(11) == 0) ? NL_CHAR : $urandom_range(255),
				$urandom_range(8191), $urandom_range(8191), 1, 0);
		push_item(REQ_LSTART, 0, 0, 8191, LOAD_BYTES, 1, 0);
		push_item(REQ_LATPOS, 8191, 0, 0, LOAD_BYTES, 1, 0);
		push_item(REQ_LSTART, 8191, 0, 0, 8191, 1, 0);
		push_item(REQ_LATPOS, 0, 0, 0, DEPTH, 1, 0);
		for (int ph = 1; ph <= 3; ph++)
			for (int i = 0; i < RANDOM_ITEMS; i++)
				add_random_item(ph, (ph == 2 && i == 0) || $urandom_range(149) == 0);

		do
			@(negedge clk);
		while (item_q.size() != 0 || s_tvalid || answer_q.size() != 0);
		repeat (40) @(negedge clk);

		$display("Sent %0d writes, %0d notifies and %0d queries; checked %0d answers,",
			n_writes, n_notifies, n_queries, n_checked);
		$display("%0d of them for absent lines, across three handshake pacing phases.",
			n_absent);
		if (n_errors == 0) begin
			$display("PASS memo_line_index_unit");
		end else begin
			$display("FAIL memo_line_index_unit");
		end
		$finish;
	end

endmodule
